### hdl/one_wire_bus_master_defines.svh
// Assertion macros for the one-wire bus master
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

`ifndef SYNTHESIS

`define OWBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("owbm check failed");

`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owbm check failed");

`else

`define OWBM_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/owbm_pkg.sv
// Types, constants and helpers shared by the one-wire bus master
`default_nettype none

package owbm_pkg;

	localparam int unsigned DEF_BITS_PER_BYTE = 8;
	localparam int unsigned TIME_W            = 10;
	localparam int unsigned CFG_IDX_W         = 3;
	// power of two
	localparam int unsigned QUEUE_DEPTH       = 2;

	typedef logic [TIME_W-1:0] usec_t;

	localparam logic [2:0] OP_TICK       = 3'd0;
	localparam logic [2:0] OP_RESET      = 3'd1;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
	localparam logic [2:0] OP_READ_BYTE  = 3'd3;
	localparam logic [2:0] OP_READ_BIT   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_HOLD     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd7;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] write_byte;
		logic       line_level;
	} in_beat_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       device_present;
	} out_beat_t;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_RESET,
		CMD_WRITE,
		CMD_RD_BYTE,
		CMD_RD_BIT
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] write_byte;
		logic       line_level;
	} cmd_beat_t;

	typedef struct packed {
		usec_t reset_low_time;
		usec_t presence_wait_time;
		usec_t write_low_time;
		usec_t write_hold_time;
		usec_t read_low_time;
		usec_t read_sample_time;
		usec_t read_hold_time;
		usec_t recovery_time;
	} cfg_t;

	localparam cfg_t CFG_RESET_VALUE = '{
		reset_low_time:     10'd480,
		presence_wait_time: 10'd60,
		write_low_time:     10'd10,
		write_hold_time:    10'd50,
		read_low_time:      10'd3,
		read_sample_time:   10'd9,
		read_hold_time:     10'd60,
		recovery_time:      10'd10
	};

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_POST,
		PH_WR_LOW,
		PH_WR_HOLD,
		PH_WR_REC,
		PH_RD_LOW,
		PH_RD_SAMPLE,
		PH_RD_HOLD,
		PH_FINAL
	} phase_t;

	typedef enum logic [1:0] {
		OPK_RESET,
		OPK_WRITE,
		OPK_RD_BYTE,
		OPK_RD_BIT
	} op_kind_t;

	// zero counts as one microsecond
	function automatic usec_t slot_len(input usec_t v);
		return (v == '0) ? usec_t'(1) : v;
	endfunction

endpackage

`default_nettype wire

### hdl/owbm_front.sv
// Front end: accept input beats, decode the command and queue them for the engine
`default_nettype none

module owbm_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire owbm_pkg::in_beat_t  in_data,
	output logic                     q_valid,
	input  wire                      q_pop,
	output owbm_pkg::cmd_beat_t      q_item
);
	import owbm_pkg::*;

	localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	cmd_beat_t             entries_q [QUEUE_DEPTH];
	logic      [PtrW-1:0]  wr_ptr_q;
	logic      [PtrW-1:0]  rd_ptr_q;
	logic      [CntW-1:0]  count_q;
	cmd_beat_t             item;
	logic                  push;
	logic                  pop;

	always_comb begin
		item.write_byte = in_data.write_byte;
		item.line_level = in_data.line_level;
		case (in_data.operation)
			OP_RESET:      item.cmd = CMD_RESET;
			OP_WRITE_BYTE: item.cmd = CMD_WRITE;
			OP_READ_BYTE:  item.cmd = CMD_RD_BYTE;
			OP_READ_BIT:   item.cmd = CMD_RD_BIT;
			default:       item.cmd = CMD_TICK;
		endcase
	end

	assign in_stall = (count_q == CntW'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = entries_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/owbm_engine.sv
// Back end: slot sequencer running one queued tick per cycle into out_q unless stalled
`default_nettype none

module owbm_engine #(
	parameter int unsigned BITS_PER_BYTE = owbm_pkg::DEF_BITS_PER_BYTE
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire owbm_pkg::cfg_t      cfg,
	input  wire                      q_valid,
	output logic                     q_pop,
	input  wire owbm_pkg::cmd_beat_t q_item,
	output logic                     out_valid,
	input  wire                      out_stall,
	output owbm_pkg::out_beat_t      out_data
);
	import owbm_pkg::*;

	localparam int unsigned BitsW = $clog2(BITS_PER_BYTE + 1);

	phase_t                phase_q;
	usec_t                 time_q;
	logic     [BitsW-1:0]  bits_q;
	logic     [7:0]        tx_q;
	logic     [7:0]        rx_q;
	logic                  pres_q;
	op_kind_t              kind_q;
	logic                  out_valid_q;
	out_beat_t             out_q;

	phase_t                phase_d;
	usec_t                 time_d;
	logic     [BitsW-1:0]  bits_d;
	logic     [7:0]        tx_d;
	logic     [7:0]        rx_d;
	logic                  pres_d;
	op_kind_t              kind_d;
	out_beat_t             res;

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		phase_d = phase_q;
		time_d  = time_q;
		bits_d  = bits_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		pres_d  = pres_q;
		kind_d  = kind_q;
		res     = '0;

		if (phase_q == PH_IDLE) begin
			case (q_item.cmd)
				CMD_RESET: begin
					kind_d  = OPK_RESET;
					phase_d = PH_RST_LOW;
					time_d  = slot_len(cfg.reset_low_time);
				end
				CMD_WRITE: begin
					kind_d  = OPK_WRITE;
					tx_d    = q_item.write_byte;
					bits_d  = BitsW'(BITS_PER_BYTE);
					phase_d = PH_WR_LOW;
					time_d  = slot_len(cfg.write_low_time);
				end
				CMD_RD_BYTE: begin
					kind_d  = OPK_RD_BYTE;
					rx_d    = '0;
					bits_d  = BitsW'(BITS_PER_BYTE);
					phase_d = PH_RD_LOW;
					time_d  = slot_len(cfg.read_low_time);
				end
				CMD_RD_BIT: begin
					kind_d  = OPK_RD_BIT;
					bits_d  = BitsW'(1);
					phase_d = PH_RD_LOW;
					time_d  = slot_len(cfg.read_low_time);
				end
				default: ;
			endcase
		end

		if (phase_d != PH_IDLE) begin
			res.busy_res  = 1'b1;
			res.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW)
				|| (phase_d == PH_RD_LOW) || ((phase_d == PH_WR_HOLD) && !tx_d[0]);
			if (time_d > usec_t'(1)) begin
				time_d = time_d - usec_t'(1);
			end else begin
				case (phase_d)
					PH_RST_LOW: begin
						phase_d = PH_RST_WAIT;
						time_d  = slot_len(cfg.presence_wait_time);
					end
					PH_RST_WAIT: begin
						pres_d  = !q_item.line_level;
						phase_d = PH_RST_POST;
						time_d  = slot_len(cfg.reset_low_time);
					end
					PH_WR_LOW: begin
						phase_d = PH_WR_HOLD;
						time_d  = slot_len(cfg.write_hold_time);
					end
					PH_WR_HOLD: begin
						phase_d = PH_WR_REC;
						time_d  = slot_len(cfg.recovery_time);
					end
					PH_WR_REC: begin
						tx_d   = {1'b0, tx_d[7:1]};
						bits_d = bits_d - BitsW'(1);
						if (bits_d != '0) begin
							phase_d = PH_WR_LOW;
							time_d  = slot_len(cfg.write_low_time);
						end else begin
							phase_d = PH_FINAL;
							time_d  = slot_len(cfg.recovery_time);
						end
					end
					PH_RD_LOW: begin
						phase_d = PH_RD_SAMPLE;
						time_d  = slot_len(cfg.read_sample_time);
					end
					PH_RD_SAMPLE: begin
						if (kind_d == OPK_RD_BIT) begin
							rx_d = {q_item.line_level, 7'b0};
						end else begin
							rx_d = {q_item.line_level, rx_d[7:1]};
						end
						phase_d = PH_RD_HOLD;
						time_d  = slot_len(cfg.read_hold_time);
					end
					PH_RD_HOLD: begin
						bits_d = bits_d - BitsW'(1);
						if (bits_d != '0) begin
							phase_d = PH_RD_LOW;
							time_d  = slot_len(cfg.read_low_time);
						end else begin
							phase_d = PH_FINAL;
							time_d  = slot_len(cfg.recovery_time);
						end
					end
					default: begin
						phase_d      = PH_IDLE;
						time_d       = '0;
						res.done_res = 1'b1;
					end
				endcase
			end
		end

		res.read_data      = rx_d;
		res.device_present = pres_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			time_q      <= '0;
			bits_q      <= '0;
			tx_q        <= '0;
			rx_q        <= '0;
			pres_q      <= 1'b0;
			kind_q      <= OPK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q     <= phase_d;
				time_q      <= time_d;
				bits_q      <= bits_d;
				tx_q        <= tx_d;
				rx_q        <= rx_d;
				pres_q      <= pres_d;
				kind_q      <= kind_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

### hdl/one_wire_bus_master.sv
// One-wire bus master top level: configuration registers, front queue and slot engine
`default_nettype none

// Every accepted input beat is one microsecond of bus time and yields exactly one output beat
// giving the line drive, busy and done flags, the receive shift register and the presence
// flag. Reset, write-byte, read-byte and read-bit commands are taken only when no operation is
// running; otherwise the command beat just advances the running one. Unless the output stalls,
// the block sustains one beat per clock cycle: a two-entry queue after the input decode feeds
// the slot engine, which retires one tick per cycle into the output register. The input stalls
// once the queue holds two beats. The user must write the eight timing registers through the
// configuration port only while the block is idle; the block itself does not enforce this.

`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master #(
	parameter int unsigned BITS_PER_BYTE = owbm_pkg::DEF_BITS_PER_BYTE
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire owbm_pkg::in_beat_t             in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output owbm_pkg::out_beat_t                 out_data,
	input  wire                                 cfg_we,
	input  wire  [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [owbm_pkg::TIME_W-1:0]         cfg_data
);
	import owbm_pkg::*;

	cfg_t      cfg_q;
	logic      q_valid;
	logic      q_pop;
	cmd_beat_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET_VALUE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESET_LOW:     cfg_q.reset_low_time     <= cfg_data;
				REG_PRESENCE_WAIT: cfg_q.presence_wait_time <= cfg_data;
				REG_WRITE_LOW:     cfg_q.write_low_time     <= cfg_data;
				REG_WRITE_HOLD:    cfg_q.write_hold_time    <= cfg_data;
				REG_READ_LOW:      cfg_q.read_low_time      <= cfg_data;
				REG_READ_SAMPLE:   cfg_q.read_sample_time   <= cfg_data;
				REG_READ_HOLD:     cfg_q.read_hold_time     <= cfg_data;
				REG_RECOVERY:      cfg_q.recovery_time      <= cfg_data;
				default: ;
			endcase
		end
	end

	owbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	owbm_engine #(
		.BITS_PER_BYTE (BITS_PER_BYTE)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`OWBM_ASSERT_SAME(a_done_is_busy, clk, arst_n, out_valid && out_data.done_res, out_data.busy_res)
	`OWBM_ASSERT_SAME(a_drive_is_busy, clk, arst_n, out_valid && out_data.drive_low, out_data.busy_res)
	`OWBM_ASSERT_NEXT(a_pop_fills_out, clk, arst_n, q_pop, out_valid)

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the one-wire bus master: per-tick bus prediction against every result beat
module tb_top;
	import owbm_pkg::*;

	localparam int          STALL_LIMIT    = 2000;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          RANDOM_PHASES  = 8;
	localparam int          BEATS_PER_SET  = 150;
	localparam int          OP_SPARE_FIRST = OP_READ_BIT + 1;
	localparam int          OP_SPARE_LAST  = 7;
	localparam logic [3:0]  BYTE_BITS      = 4'(DEF_BITS_PER_BYTE);

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_beat_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_beat_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [TIME_W-1:0]      cfg_data = '0;

	in_beat_t               beat_backlog[$];
	out_beat_t              bus_expect[$];
	logic                   in_beat_taken = 1'b0;
	int                     send_idle_pct = 0;
	int                     recv_stall_pct = 0;
	logic                   hold_flip = 1'b0;
	logic                   hold_seen = 1'b0;
	int                     hold_left = 0;
	int                     quiet_cycles = 0;
	int                     errors = 0;
	int                     beats_checked = 0;
	int                     settings_used = 0;
	int                     done_by_kind [4];
	out_beat_t              predicted;
	out_beat_t              wanted;

	// bus predictor state
	cfg_t                   timing = CFG_RESET_VALUE;
	phase_t                 bus_ph = PH_IDLE;
	usec_t                  bus_left = '0;
	logic [3:0]             bus_bits = '0;
	logic [7:0]             bus_tx = '0;
	logic [7:0]             bus_rx = '0;
	logic                   bus_present = 1'b0;
	op_kind_t               bus_kind = OPK_RESET;

	one_wire_bus_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic load_phase(input phase_t p, input usec_t d);
		bus_ph = p;
		bus_left = (d == '0) ? 10'd1 : d;
	endtask

	task automatic step_bus(input in_beat_t b, output out_beat_t r);
		logic drv;
		logic busy;
		logic done;
		drv = 1'b0;
		busy = 1'b0;
		done = 1'b0;
		if (bus_ph == PH_IDLE) begin
			case (b.operation)
				OP_RESET: begin
					bus_kind = OPK_RESET;
					load_phase(PH_RST_LOW, timing.reset_low_time);
				end
				OP_WRITE_BYTE: begin
					bus_kind = OPK_WRITE;
					bus_tx = b.write_byte;
					bus_bits = BYTE_BITS;
					load_phase(PH_WR_LOW, timing.write_low_time);
				end
				OP_READ_BYTE: begin
					bus_kind = OPK_RD_BYTE;
					bus_rx = '0;
					bus_bits = BYTE_BITS;
					load_phase(PH_RD_LOW, timing.read_low_time);
				end
				OP_READ_BIT: begin
					bus_kind = OPK_RD_BIT;
					bus_bits = 4'd1;
					load_phase(PH_RD_LOW, timing.read_low_time);
				end
				default: ;
			endcase
		end
		if (bus_ph != PH_IDLE) begin
			busy = 1'b1;
			if (bus_ph == PH_RST_LOW || bus_ph == PH_WR_LOW || bus_ph == PH_RD_LOW)
				drv = 1'b1;
			else if (bus_ph == PH_WR_HOLD)
				drv = ~bus_tx[0];
			if (bus_left > 10'd1) begin
				bus_left = bus_left - 10'd1;
			end else begin
				case (bus_ph)
					PH_RST_LOW: load_phase(PH_RST_WAIT, timing.presence_wait_time);
					PH_RST_WAIT: begin
						bus_present = ~b.line_level;
						load_phase(PH_RST_POST, timing.reset_low_time);
					end
					PH_WR_LOW: load_phase(PH_WR_HOLD, timing.write_hold_time);
					PH_WR_HOLD: load_phase(PH_WR_REC, timing.recovery_time);
					PH_WR_REC: begin
						bus_tx = bus_tx >> 1;
						bus_bits = bus_bits - 4'd1;
						if (bus_bits != '0)
							load_phase(PH_WR_LOW, timing.write_low_time);
						else
							load_phase(PH_FINAL, timing.recovery_time);
					end
					PH_RD_LOW: load_phase(PH_RD_SAMPLE, timing.read_sample_time);
					PH_RD_SAMPLE: begin
						if (bus_kind == OPK_RD_BIT)
							bus_rx = {b.line_level, 7'b0};
						else
							bus_rx = {b.line_level, bus_rx[7:1]};
						load_phase(PH_RD_HOLD, timing.read_hold_time);
					end
					PH_RD_HOLD: begin
						bus_bits = bus_bits - 4'd1;
						if (bus_bits != '0)
							load_phase(PH_RD_LOW, timing.read_low_time);
						else
							load_phase(PH_FINAL, timing.recovery_time);
					end
					default: begin
						bus_ph = PH_IDLE;
						bus_left = '0;
						done = 1'b1;
						done_by_kind[bus_kind]++;
					end
				endcase
			end
		end
		r.drive_low = drv;
		r.busy_res = busy;
		r.done_res = done;
		r.read_data = bus_rx;
		r.device_present = bus_present;
	endtask

	// check first so that an unexpected beat is never masked by this cycle's prediction
	always @(posedge clk) begin
		in_beat_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (bus_expect.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, got %h", $time, out_data);
				end else begin
					wanted = bus_expect.pop_front();
					if (out_data !== wanted) begin
						errors++;
						$display("%0t: beat %0d expected drv %b busy %b done %b data %h pres %b,",
							$time, beats_checked, wanted.drive_low, wanted.busy_res,
							wanted.done_res, wanted.read_data, wanted.device_present,
							" got drv %b busy %b done %b data %h pres %b",
							out_data.drive_low, out_data.busy_res, out_data.done_res,
							out_data.read_data, out_data.device_present);
					end
					beats_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				step_bus(in_data, predicted);
				bus_expect.push_back(predicted);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// hold a stalled beat, otherwise offer the next one unless idling
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_beat_taken)) begin
			if (beat_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= beat_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_flip != hold_seen) begin
			hold_seen = hold_flip;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic queue_beat(input logic [2:0] op, input logic [7:0] wb, input logic lvl);
		in_beat_t b;
		b.operation = op;
		b.write_byte = wb;
		b.line_level = lvl;
		beat_backlog.push_back(b);
	endtask

	task automatic queue_tick();
		queue_beat(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic queue_random_beat();
		int r;
		logic [2:0] op;
		r = $urandom_range(99);
		if (r < 9)
			op = 3'($urandom_range(OP_READ_BIT, OP_RESET));
		else if (r < 11)
			op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		else
			op = OP_TICK;
		queue_beat(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic drain();
		while (beat_backlog.size() != 0 || in_valid || bus_expect.size() != 0)
			@(posedge clk);
	endtask

	// run out the operation in progress, then let the pipeline empty
	task automatic settle();
		drain();
		while (bus_ph != PH_IDLE) begin
			repeat (16) queue_tick();
			drain();
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input usec_t v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
	endtask

	task automatic apply_cfg(input cfg_t c);
		write_reg(REG_RESET_LOW, c.reset_low_time);
		write_reg(REG_PRESENCE_WAIT, c.presence_wait_time);
		write_reg(REG_WRITE_LOW, c.write_low_time);
		write_reg(REG_WRITE_HOLD, c.write_hold_time);
		write_reg(REG_READ_LOW, c.read_low_time);
		write_reg(REG_READ_SAMPLE, c.read_sample_time);
		write_reg(REG_READ_HOLD, c.read_hold_time);
		write_reg(REG_RECOVERY, c.recovery_time);
		@(negedge clk);
		cfg_we <= 1'b0;
		timing = c;
		settings_used++;
		repeat (2) @(posedge clk);
	endtask

	function automatic usec_t rand_time();
		if ($urandom_range(4) == 0)
			return usec_t'($urandom_range(20, 4));
		return usec_t'($urandom_range(3, 0));
	endfunction

	function automatic cfg_t rand_cfg();
		return {rand_time(), rand_time(), rand_time(), rand_time(),
			rand_time(), rand_time(), rand_time(), rand_time()};
	endfunction

	function automatic cfg_t flat_cfg(input usec_t v);
		return {v, v, v, v, v, v, v, v};
	endfunction

	initial begin
		int p;
		int k;
		for (k = 0; k < 4; k++)
			done_by_kind[k] = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// read slot at the reset timing values
		queue_beat(OP_READ_BIT, 8'h00, 1'b1);
		settle();

		apply_cfg(flat_cfg(10'd1));
		queue_beat(OP_RESET, 8'h00, 1'b1);
		queue_beat(OP_TICK, 8'h00, 1'b0);
		queue_beat(OP_TICK, 8'h00, 1'b1);
		queue_beat(OP_RESET, 8'hFF, 1'b0);
		queue_beat(OP_TICK, 8'hFF, 1'b1);
		queue_beat(OP_TICK, 8'h00, 1'b0);
		queue_beat(OP_READ_BIT, 8'h00, 1'b0);
		queue_beat(OP_TICK, 8'h00, 1'b1);
		queue_beat(OP_TICK, 8'h00, 1'b0);
		queue_beat(OP_TICK, 8'h00, 1'b0);
		queue_beat(OP_READ_BIT, 8'hFF, 1'b1);
		queue_beat(OP_TICK, 8'hFF, 1'b0);
		queue_beat(OP_TICK, 8'h00, 1'b1);
		queue_beat(OP_TICK, 8'h00, 1'b1);
		for (k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
			queue_beat(k[2:0], 8'hFF, 1'b1);
		// commands arriving mid-write are dropped
		queue_beat(OP_WRITE_BYTE, 8'hFF, 1'b0);
		for (k = 0; k < 24; k++)
			queue_beat(k[0] ? OP_READ_BYTE : OP_RESET, 8'h00, k[1]);
		settle();

		apply_cfg(flat_cfg('0));
		queue_beat(OP_WRITE_BYTE, 8'h00, 1'b1);
		settle();
		queue_beat(OP_READ_BYTE, 8'h5A, 1'b1);
		settle();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 49; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 49; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			apply_cfg(rand_cfg());
			for (k = 0; k < BEATS_PER_SET; k++)
				queue_random_beat();
			if (p == 0)
				hold_flip = ~hold_flip;
			settle();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;

		drain();
		repeat (20) @(posedge clk);
		$display("Checked %0d result beats over %0d timing settings, idle and stall mixes included.",
			beats_checked, settings_used);
		$display("Completed %0d resets, %0d byte writes, %0d byte reads, %0d bit reads.",
			done_by_kind[OPK_RESET], done_by_kind[OPK_WRITE], done_by_kind[OPK_RD_BYTE],
			done_by_kind[OPK_RD_BIT]);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
